// File: sv/fdaf_pkg.sv
// shared types and constants of the decimal amount formatter
package fdaf_pkg;

   // input amount and its decimal expansion
   localparam int AMOUNT_WIDTH = 64;
   localparam int BCD_DIGITS = 20;
   localparam int TOTAL_DIGITS = 19;
   localparam int DIGITS_WIDTH = TOTAL_DIGITS * 4;
   localparam int FRACTION_DIGITS_DEFAULT = 8;

   // text length fits 5 bits, at most 24 characters
   localparam int LEN_WIDTH = 5;
   localparam int POS_WIDTH = 5;

   // configuration port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CAP_WIDTH = 8;
   localparam logic CSR_IDX_OUT_CAPACITY = 1'b0;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 8'd32;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_NO_FIT    = 2'd2
   } fdaf_status_type;

   // converter to sequencer signals
   typedef struct packed {
      logic done;
      logic overflow;
   } fdaf_conv_status_type;

endpackage

// File: sv/fdaf_dabble.sv
// bit-serial binary to packed decimal converter (shift and add three)
module fdaf_dabble
   import fdaf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [AMOUNT_WIDTH-1:0]   amount,
   output fdaf_conv_status_type      conv_status,
   output logic [DIGITS_WIDTH-1:0]   digits
);

   localparam int BCD_WIDTH = BCD_DIGITS * 4;
   localparam int CNT_WIDTH = $clog2(AMOUNT_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(AMOUNT_WIDTH - 1);

   logic [AMOUNT_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]    bcd_ff, bcd_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [BCD_WIDTH-1:0]    adjusted;

   // each digit of five or more gets three before the shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adjusted[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            adjusted[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = amount;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adjusted[BCD_WIDTH-2:0], bin_ff[AMOUNT_WIDTH-1]};
         bin_in = {bin_ff[AMOUNT_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign conv_status.done     = done_ff;
   assign conv_status.overflow = (bcd_ff[BCD_WIDTH-1 -: 4] != 4'd0);
   assign digits               = bcd_ff[DIGITS_WIDTH-1:0];

endmodule

// File: sv/fixed_decimal_amount_formatter_unit.sv
// top level of the decimal amount formatter
// One amount of base units with FRACTION_DIGITS implied decimal places is taken per
// transaction and returned as ASCII text, one character per result transaction: a
// four-character ticker prefix, the integer part without leading zeros (a single "0"
// below one unit), then a point and the fraction with trailing zeros trimmed; the point
// goes when the fraction is zero. The final character carries last. Amounts of 10^19 or
// more give a single status result "too large", and text whose length is not below
// out_capacity - 1 gives a single status result "does not fit"; status results carry
// character 0 and last 1. After acceptance the amount passes the bit-serial decimal
// converter (one amount bit per cycle), whose overflow gives "too large"; otherwise a
// digit-serial scan finds the first integer digit and the last fraction digit, and a
// sizing step either gives "does not fit" or starts the text: the prefix characters,
// one step per integer digit position whether printed or skipped as a leading zero,
// the point and the fraction digits; an output stall holds the sequence. The input is
// stalled from acceptance until the final result has been loaded into the output
// register, so the next amount can be taken in the next cycle. out_capacity lies at
// byte address 0 of the register port.
module fixed_decimal_amount_formatter_unit
   import fdaf_pkg::*;
#(
   parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // input channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [AMOUNT_WIDTH-1:0]   req_amount,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_character,
   output logic                      rsp_last,
   output logic [1:0]                rsp_status,
   // register port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   // digit positions count from the most significant of the nineteen digits
   localparam int INT_DIGITS = TOTAL_DIGITS - FRACTION_DIGITS;
   localparam logic [POS_WIDTH-1:0] INT_D = POS_WIDTH'(INT_DIGITS);
   localparam logic [POS_WIDTH-1:0] INT_LAST = POS_WIDTH'(INT_DIGITS - 1);
   localparam logic [POS_WIDTH-1:0] SCAN_LAST = POS_WIDTH'(TOTAL_DIGITS - 1);
   localparam logic [POS_WIDTH-1:0] PREFIX_LAST = POS_WIDTH'(3);
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_POINT = 8'h2e;
   // ticker prefix, four characters ending in a space
   localparam logic [7:0] PREFIX [4] = '{8'h46, 8'h43, 8'h54, 8'h20};

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_SCAN,
      S_SIZE,
      S_FAIL,
      S_PREFIX,
      S_DIGITS
   } state_type;

   // register port
   logic [CAP_WIDTH-1:0] cap_ff;
   logic                 csr_write;

   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_OUT_CAPACITY) ?
                       CSR_DATA_WIDTH'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write && csr_paddr[2] == CSR_IDX_OUT_CAPACITY) begin
         cap_ff <= csr_pwdata[CAP_WIDTH-1:0];
      end
   end

   // converter
   fdaf_conv_status_type    conv_st;
   logic [DIGITS_WIDTH-1:0] conv_digits;
   logic                    req_accept;

   assign req_accept = req_valid & ~req_stall;

   fdaf_dabble u_dabble (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .amount      (req_amount),
      .conv_status (conv_st),
      .digits      (conv_digits)
   );

   // sequencer
   state_type               state_ff, state_in;
   logic [DIGITS_WIDTH-1:0] dig_ff, dig_in;
   logic [POS_WIDTH-1:0]    pos_ff, pos_in;
   logic                    int_found_ff, int_found_in;
   logic [POS_WIDTH-1:0]    first_ff, first_in;
   logic                    frac_any_ff, frac_any_in;
   logic [POS_WIDTH-1:0]    last_frac_ff, last_frac_in;
   logic                    dot_done_ff, dot_done_in;
   fdaf_status_type         fail_code_ff, fail_code_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              char_ff, char_in;
   logic                    last_ff, last_in;
   fdaf_status_type         status_ff, status_in;

   logic                    out_free;
   logic [3:0]              top_digit;
   logic [DIGITS_WIDTH-1:0] dig_rot;
   logic [LEN_WIDTH-1:0]    int_len;
   logic [LEN_WIDTH-1:0]    frac_len;
   logic [LEN_WIDTH-1:0]    text_len;
   logic [CAP_WIDTH:0]      need;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign top_digit = dig_ff[DIGITS_WIDTH-1 -: 4];
   assign dig_rot   = {dig_ff[DIGITS_WIDTH-5:0], top_digit};

   // text length from the scan results
   assign int_len  = int_found_ff ? (INT_D - first_ff) : LEN_WIDTH'(1);
   assign frac_len = frac_any_ff ? (last_frac_ff - INT_D + 1'b1) : '0;
   assign text_len = LEN_WIDTH'(4) + int_len + (frac_any_ff ? frac_len + 1'b1 : '0);
   // does not fit when len >= cap - 1, covering capacities of zero and one
   assign need     = (CAP_WIDTH+1)'(text_len) + 1'b1;

   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      pos_in       = pos_ff;
      int_found_in = int_found_ff;
      first_in     = first_ff;
      frac_any_in  = frac_any_ff;
      last_frac_in = last_frac_ff;
      dot_done_in  = dot_done_ff;
      fail_code_in = fail_code_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      char_in      = char_ff;
      last_in      = last_ff;
      status_in    = status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_CONV;
            end
         end

         S_CONV: begin
            if (conv_st.done) begin
               if (conv_st.overflow) begin
                  fail_code_in = STATUS_TOO_LARGE;
                  state_in     = S_FAIL;
               end else begin
                  dig_in       = conv_digits;
                  pos_in       = '0;
                  int_found_in = 1'b0;
                  first_in     = '0;
                  frac_any_in  = 1'b0;
                  last_frac_in = '0;
                  state_in     = S_SCAN;
               end
            end
         end

         // one digit a cycle; a full rotation restores the alignment
         S_SCAN: begin
            dig_in = dig_rot;
            pos_in = pos_ff + 1'b1;
            if (top_digit != 4'd0) begin
               if (pos_ff < INT_D) begin
                  if (!int_found_ff) begin
                     int_found_in = 1'b1;
                     first_in     = pos_ff;
                  end
               end else begin
                  frac_any_in  = 1'b1;
                  last_frac_in = pos_ff;
               end
            end
            if (pos_ff == SCAN_LAST) begin
               pos_in   = '0;
               state_in = S_SIZE;
            end
         end

         S_SIZE: begin
            // below one unit the last integer digit, a zero, is printed
            if (!int_found_ff) begin
               first_in = INT_LAST;
            end
            if (need >= (CAP_WIDTH+1)'(cap_ff)) begin
               fail_code_in = STATUS_NO_FIT;
               state_in     = S_FAIL;
            end else begin
               pos_in   = '0;
               state_in = S_PREFIX;
            end
         end

         S_FAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = '0;
               last_in      = 1'b1;
               status_in    = fail_code_ff;
               state_in     = S_IDLE;
            end
         end

         S_PREFIX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = PREFIX[pos_ff[1:0]];
               last_in      = 1'b0;
               status_in    = STATUS_OK;
               pos_in       = pos_ff + 1'b1;
               if (pos_ff == PREFIX_LAST) begin
                  pos_in      = '0;
                  dot_done_in = 1'b0;
                  state_in    = S_DIGITS;
               end
            end
         end

         S_DIGITS: begin
            if (out_free) begin
               if (pos_ff == INT_D && frac_any_ff && !dot_done_ff) begin
                  rsp_valid_in = 1'b1;
                  char_in      = CHAR_POINT;
                  last_in      = 1'b0;
                  status_in    = STATUS_OK;
                  dot_done_in  = 1'b1;
               end else begin
                  dig_in = dig_rot;
                  pos_in = pos_ff + 1'b1;
                  if (pos_ff < INT_D) begin
                     // leading zeros are shifted out without a result
                     if (pos_ff >= first_ff) begin
                        rsp_valid_in = 1'b1;
                        char_in      = CHAR_ZERO | {4'd0, top_digit};
                        last_in      = (pos_ff == INT_LAST) && !frac_any_ff;
                        status_in    = STATUS_OK;
                        if (pos_ff == INT_LAST && !frac_any_ff) begin
                           state_in = S_IDLE;
                        end
                     end
                  end else begin
                     rsp_valid_in = 1'b1;
                     char_in      = CHAR_ZERO | {4'd0, top_digit};
                     last_in      = (pos_ff == last_frac_ff);
                     status_in    = STATUS_OK;
                     if (pos_ff == last_frac_ff) begin
                        state_in = S_IDLE;
                     end
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dig_ff       <= dig_in;
      pos_ff       <= pos_in;
      int_found_ff <= int_found_in;
      first_ff     <= first_in;
      frac_any_ff  <= frac_any_in;
      last_frac_ff <= last_frac_in;
      dot_done_ff  <= dot_done_in;
      fail_code_ff <= fail_code_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
      status_ff    <= status_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_status    = status_ff;

   // checks

   // status results always close the transaction
   property p_status_is_last;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && status_ff != STATUS_OK) |-> (last_ff && char_ff == 8'd0);
   endproperty
   a_status_is_last: assert property (p_status_is_last)
      else $error("status result without last or with a character");

   // text results never carry a zero character
   property p_text_nonzero;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && status_ff == STATUS_OK) |-> (char_ff != 8'd0);
   endproperty
   a_text_nonzero: assert property (p_text_nonzero)
      else $error("text result with zero character");

   // converter finishes only while the sequencer waits for it
   property p_conv_done_in_conv;
      @(posedge clock) disable iff (reset)
         conv_st.done |-> (state_ff == S_CONV);
   endproperty
   a_conv_done_in_conv: assert property (p_conv_done_in_conv)
      else $error("conversion finished outside the conversion state");

   // an accepted transaction starts the conversion
   property p_accept_starts_conv;
      @(posedge clock) disable iff (reset)
         req_accept |=> (state_ff == S_CONV);
   endproperty
   a_accept_starts_conv: assert property (p_accept_starts_conv)
      else $error("accepted transaction did not enter conversion");

   // a last result returns the sequencer to idle
   property p_last_goes_idle;
      @(posedge clock) disable iff (reset)
         (rsp_valid_in && !(rsp_valid_ff && rsp_stall) && last_in) |=> (state_ff == S_IDLE);
   endproperty
   a_last_goes_idle: assert property (p_last_goes_idle)
      else $error("sequencer busy after its last result");

endmodule

// File: tb/sv/fixed_decimal_amount_formatter_unit_tb.sv
// self-checking testbench for the decimal amount formatter top level
`timescale 1ns / 100ps

module fixed_decimal_amount_formatter_unit_tb
   import fdaf_pkg::*;
();

   // timing and run shape
   localparam int FRAC_DIGITS = FRACTION_DIGITS_DEFAULT;
   localparam int RESET_CYCLES = 7;
   localparam int SETTLE_CYCLES = 8;      // idle pause before a register write
   localparam int DRAIN_CYCLES = 150;     // a little over one item's latency
   localparam int HOLD_OFF_CYCLES = 400;  // long receiver hold-off
   localparam int QUIET_LIMIT = 5000;     // cycles with no transaction at all
   localparam int IDLE_PERCENT = 25;
   localparam int REPORT_LIMIT = 10;

   // formatting constants
   localparam logic [63:0] AMOUNT_LIMIT = 64'd10000000000000000000;
   localparam logic [31:0] TICKER = {8'h46, 8'h43, 8'h54, 8'h20};  // ticker prefix
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DECIMAL_POINT = 8'h2E;
   localparam logic [CSR_ADDR_WIDTH-1:0] CAPACITY_ADDR = {CSR_IDX_OUT_CAPACITY, 2'b00};

   // one character (or status) transaction on the result channel
   typedef struct packed {
      logic [7:0]      character;
      logic            last;
      fdaf_status_type status;
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // input channel
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_amount = '0;

   // result channel
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_character;
   logic       rsp_last;
   logic [1:0] rsp_status;

   // register port
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // predictor state: the capacity register as last written
   logic [CAP_WIDTH-1:0] capacity_setting = CAP_RESET;

   // amounts waiting to be offered and characters still owed by the block
   logic [63:0]   pending_amounts [$];
   text_char_type expected_chars [$];
   text_char_type oldest;

   // handshake bookkeeping shared between the clocked processes
   bit req_taken = 1'b0;
   bit steady_flow = 1'b0;        // no idling on either side while set
   bit hold_off_request = 1'b0;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   // counters for the summary and the verdict
   int error_count = 0;
   int amounts_taken = 0;
   int chars_checked = 0;
   int too_large_seen = 0;
   int no_fit_seen = 0;
   int phase_count = 0;

   fixed_decimal_amount_formatter_unit #(
      .FRACTION_DIGITS(FRAC_DIGITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_amount   (req_amount),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] pow10(input int k);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < k; i++)
         p = p * 64'd10;
      return p;
   endfunction

   // work out the text for one amount and queue the characters it should produce
   function automatic void predict_text(input logic [63:0] amount);
      logic [7:0]    text [0:47];
      logic [7:0]    whole_digits [0:19];
      logic [7:0]    frac_digits [0:FRAC_DIGITS-1];
      logic [63:0]   whole;
      logic [63:0]   frac;
      logic [63:0]   scale;
      text_char_type item;
      int            n;
      int            nd;
      int            frac_len;
      n = 0;
      nd = 0;
      // too large wins over every capacity check
      if (amount >= AMOUNT_LIMIT) begin
         item.character = 8'd0;
         item.last = 1'b1;
         item.status = STATUS_TOO_LARGE;
         expected_chars.push_back(item);
         return;
      end
      scale = pow10(FRAC_DIGITS);
      whole = amount / scale;
      frac = amount % scale;
      for (int i = 0; i < 4; i++) begin
         text[n] = TICKER[31 - 8 * i -: 8];
         n++;
      end
      // integer part, a lone zero below one unit
      if (whole == 64'd0) begin
         text[n] = DIGIT_ZERO;
         n++;
      end else begin
         while (whole != 64'd0) begin
            whole_digits[nd] = DIGIT_ZERO + 8'(whole % 64'd10);
            whole = whole / 64'd10;
            nd++;
         end
         while (nd > 0) begin
            nd--;
            text[n] = whole_digits[nd];
            n++;
         end
      end
      // fraction keeps leading zeros, loses trailing ones
      for (int i = FRAC_DIGITS - 1; i >= 0; i--) begin
         frac_digits[i] = DIGIT_ZERO + 8'(frac % 64'd10);
         frac = frac / 64'd10;
      end
      frac_len = FRAC_DIGITS;
      while (frac_len > 0 && frac_digits[frac_len - 1] == DIGIT_ZERO)
         frac_len--;
      if (frac_len > 0) begin
         text[n] = DECIMAL_POINT;
         n++;
         for (int i = 0; i < frac_len; i++) begin
            text[n] = frac_digits[i];
            n++;
         end
      end
      // room for the text and a terminator, else one no-fit status
      if (capacity_setting < 8'd2 || n >= int'(capacity_setting) - 1) begin
         item.character = 8'd0;
         item.last = 1'b1;
         item.status = STATUS_NO_FIT;
         expected_chars.push_back(item);
         return;
      end
      for (int i = 0; i < n; i++) begin
         item.character = text[i];
         item.last = (i == n - 1);
         item.status = STATUS_OK;
         expected_chars.push_back(item);
      end
   endfunction

   // random amount, shaped so every text length and both limits are reached
   function automatic logic [63:0] random_amount();
      logic [63:0] wide;
      logic [63:0] whole;
      logic [63:0] frac;
      int          trimmed;
      wide = {$urandom, $urandom};
      whole = {$urandom, $urandom} % pow10($urandom_range(1, 11));
      trimmed = $urandom_range(0, FRAC_DIGITS);
      frac = ({$urandom, $urandom} % pow10(FRAC_DIGITS - trimmed)) * pow10(trimmed);
      case ($urandom_range(0, 9))
         0, 1: return wide;                            // whole 64-bit range
         2: return frac;                               // below one unit
         3: return whole * pow10(FRAC_DIGITS);         // whole units, no point
         4: begin
            // either side of the too-large threshold
            if ($urandom_range(0, 1) == 0)
               return AMOUNT_LIMIT - 64'($urandom_range(1, 4));
            else
               return AMOUNT_LIMIT + 64'($urandom_range(0, 3));
         end
         default: return whole * pow10(FRAC_DIGITS) + frac;
      endcase
   endfunction

   // apb write of out_capacity, then a read back of it
   task automatic program_capacity(input logic [CAP_WIDTH-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CAPACITY_ADDR;
      csr_pwdata <= CSR_DATA_WIDTH'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      capacity_setting = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_WIDTH'(value)) begin
         if (error_count < REPORT_LIMIT)
            $display("capacity read back: expected %0d, got %0d", value, csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      phase_count++;
   endtask

   // block is idle once nothing is queued, offered or owed
   task automatic wait_until_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_amounts.size() != 0 || req_valid || expected_chars.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input logic [CAP_WIDTH-1:0] cap, input int count);
      program_capacity(cap);
      repeat (count) pending_amounts.push_back(random_amount());
      wait_until_idle();
   endtask

   // driver: offers the next pending amount at the falling edge, holds it while stalled
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_amounts.size() != 0
             && (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_valid <= 1'b1;
            req_amount <= pending_amounts.pop_front();
         end else
            req_valid <= 1'b0;
      end
   end

   // receiver: random stalls, none in the steady stretch, one long hold-off on request
   always @(negedge clock) begin
      if (hold_off_request && hold_cycles < HOLD_OFF_CYCLES) begin
         hold_cycles <= hold_cycles + 1;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // monitor: predicts on each accepted amount, checks each accepted character,
   // and keeps the watchdog on transactions of any channel
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            amounts_taken++;
            predict_text(req_amount);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               // nothing owed, so any transaction here is a failure
               if (error_count < REPORT_LIMIT)
                  $display("unexpected result: char %h last %b status %0d",
                           rsp_character, rsp_last, rsp_status);
               error_count++;
            end else begin
               oldest = expected_chars.pop_front();
               chars_checked++;
               if (oldest.status == STATUS_TOO_LARGE)
                  too_large_seen++;
               if (oldest.status == STATUS_NO_FIT)
                  no_fit_seen++;
               if (rsp_character !== oldest.character || rsp_last !== oldest.last
                   || rsp_status !== oldest.status) begin
                  if (error_count < REPORT_LIMIT)
                     $display({"mismatch: expected char %h last %b status %0d,",
                               " got char %h last %b status %0d"},
                              oldest.character, oldest.last, oldest.status,
                              rsp_character, rsp_last, rsp_status);
                  error_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_psel && csr_penable && csr_pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero, limits, padding and trimming of the fraction
      program_capacity(CAP_RESET);
      pending_amounts.push_back(64'd0);
      pending_amounts.push_back(64'd1);
      pending_amounts.push_back(64'd100000);
      pending_amounts.push_back(64'd12345678);
      pending_amounts.push_back(64'd50000000);
      pending_amounts.push_back(64'd99999999);
      pending_amounts.push_back(64'd100000000);
      pending_amounts.push_back(64'd100000001);
      pending_amounts.push_back(64'd12300000010);
      pending_amounts.push_back(64'd1000000000000000000);
      pending_amounts.push_back(64'h7FFF_FFFF_FFFF_FFFF);
      pending_amounts.push_back(64'h8000_0000_0000_0000);
      pending_amounts.push_back(AMOUNT_LIMIT - 64'd1);
      pending_amounts.push_back(AMOUNT_LIMIT);
      pending_amounts.push_back(AMOUNT_LIMIT + 64'd1);
      pending_amounts.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      pending_amounts.push_back(64'd99999999900000000);
      pending_amounts.push_back(64'h5555_5555_5555_5555);
      wait_until_idle();

      // capacity zero and one: nothing fits, too large still reported as such
      program_capacity(8'd0);
      pending_amounts.push_back(64'd0);
      pending_amounts.push_back(AMOUNT_LIMIT);
      repeat (4) pending_amounts.push_back(random_amount());
      wait_until_idle();
      run_random_phase(8'd1, 6);

      // widest buffer with no idling on either side
      steady_flow = 1'b1;
      run_random_phase(8'd255, 70);
      steady_flow = 1'b0;

      // longest text at the smallest capacity that fits it, and one above
      program_capacity(8'd26);
      pending_amounts.push_back(AMOUNT_LIMIT - 64'd1);
      repeat (29) pending_amounts.push_back(random_amount());
      wait_until_idle();
      program_capacity(8'd27);
      pending_amounts.push_back(AMOUNT_LIMIT - 64'd1);
      repeat (29) pending_amounts.push_back(random_amount());
      wait_until_idle();

      // random small capacities, where fit and no-fit mix, then one of any value
      repeat (3) run_random_phase(CAP_WIDTH'($urandom_range(2, 30)), 30);
      run_random_phase(CAP_WIDTH'($urandom_range(0, 255)), 30);

      // receiver holds off while the sender keeps offering, so the block backs up
      program_capacity(CAP_RESET);
      hold_off_request = 1'b1;
      repeat (32) pending_amounts.push_back(random_amount());
      wait_until_idle();

      // let any stray result show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d amounts over %0d capacity settings:", amounts_taken, phase_count);
      $display("  %0d results, %0d too large, %0d no fit, random idling, a steady stretch",
               chars_checked, too_large_seen, no_fit_seen);
      $display("  and a %0d-cycle hold-off, capacities from 0 to 255", HOLD_OFF_CYCLES);
      if (error_count == 0 && expected_chars.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
